// ===== hw/rtl/wfd_pkg.sv =====
// Package: shared types and constants of the WebSocket frame deframer.
`timescale 1ns / 1ps
package wfd_pkg;

	// Width of the decoded payload length that is kept (16 to 64).
	localparam int unsigned LEN_BITS = 64;
	localparam logic [63:0] LEN_MAX  = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - LEN_BITS);

	// Header second byte: 7-bit length codes that announce an extended length.
	localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
	localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
	localparam logic [3:0] EXT16_BYTES    = 4'd2;
	localparam logic [3:0] EXT64_BYTES    = 4'd8;
	localparam logic [3:0] KEY_BYTES      = 4'd4;

	typedef enum logic {
		KIND_HEADER  = 1'b0,
		KIND_PAYLOAD = 1'b1
	} wfd_kind_t;

	// One classified request handed from the parser to the output side.
	typedef struct packed {
		wfd_kind_t   kind;
		logic        fin;
		logic [3:0]  opcode;
		logic        masked;
		logic [63:0] payload_length;
		logic [7:0]  raw_byte;
		logic [7:0]  key_byte;
		logic        last;
	} wfd_op_t;

	function automatic logic [63:0] clamp_len(input logic [63:0] v);
		return (v > LEN_MAX) ? LEN_MAX : v;
	endfunction

endpackage

// ===== hw/rtl/wfd_byte_if.sv =====
// Interface: received byte stream channel.
`timescale 1ns / 1ps
interface wfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== hw/rtl/wfd_result_if.sv =====
// Interface: parsed frame result channel.
`timescale 1ns / 1ps
interface wfd_result_if;
	logic        valid;
	logic        ready;
	logic        item_kind;
	logic        fin;
	logic [3:0]  opcode;
	logic        masked;
	logic [63:0] payload_length;
	logic [7:0]  data_byte;
	logic        last;

	modport source (output valid, output item_kind, output fin, output opcode,
		output masked, output payload_length, output data_byte, output last,
		input ready);
	modport sink   (input valid, input item_kind, input fin, input opcode,
		input masked, input payload_length, input data_byte, input last,
		output ready);
endinterface

// ===== hw/rtl/wfd_front.sv =====
// Front end: header parser that classifies each byte and queues result requests.
`timescale 1ns / 1ps
module wfd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           in_byte,
	input  logic                 q_ready,
	output logic                 push,
	output wfd_pkg::wfd_op_t     push_op
);

	typedef enum logic [2:0] {
		PH_HDR0  = 3'd0,
		PH_HDR1  = 3'd1,
		PH_EXT16 = 3'd2,
		PH_EXT64 = 3'd3,
		PH_KEY   = 3'd4,
		PH_DATA  = 3'd5
	} phase_t;

	phase_t      phase_q;
	logic [3:0]  field_count_q;
	logic        fin_q;
	logic [3:0]  opcode_q;
	logic        mask_q;
	logic [63:0] length_q;
	logic [63:0] bytes_left_q;
	logic [31:0] mask_key_q;
	logic [1:0]  mask_index_q;

	logic        acc;
	logic [6:0]  code;
	logic [3:0]  cnt_nxt;
	logic [3:0]  ext_need;
	logic        ext_done;
	logic [63:0] len_shift;
	logic [63:0] len_clamped;
	logic [63:0] bytes_left_nxt;
	logic [7:0]  key_byte;

	assign in_ready = q_ready;
	assign acc      = in_valid && in_ready;
	assign code     = in_byte[6:0];
	assign cnt_nxt  = field_count_q + 4'd1;
	assign ext_need = (phase_q == PH_EXT16) ? wfd_pkg::EXT16_BYTES : wfd_pkg::EXT64_BYTES;
	assign ext_done = (cnt_nxt >= ext_need);
	assign len_shift   = {length_q[55:0], in_byte};
	assign len_clamped = wfd_pkg::clamp_len(len_shift);
	assign bytes_left_nxt = (bytes_left_q != 64'd0) ? (bytes_left_q - 64'd1) : 64'd0;

	always_comb begin
		case (mask_index_q)
			2'd0:    key_byte = mask_key_q[31:24];
			2'd1:    key_byte = mask_key_q[23:16];
			2'd2:    key_byte = mask_key_q[15:8];
			default: key_byte = mask_key_q[7:0];
		endcase
	end

	// Result request built from the current byte and stored header fields
	always_comb begin
		push                   = 1'b0;
		push_op.kind           = wfd_pkg::KIND_HEADER;
		push_op.fin            = fin_q;
		push_op.opcode         = opcode_q;
		push_op.masked         = mask_q;
		push_op.payload_length = length_q;
		push_op.raw_byte       = 8'd0;
		push_op.key_byte       = 8'd0;
		push_op.last           = 1'b0;
		case (phase_q)
			PH_HDR1: begin
				push_op.masked         = in_byte[7];
				push_op.payload_length = {57'd0, code};
				push_op.last           = (code == 7'd0);
				push = acc && !in_byte[7] && (code != wfd_pkg::LEN_CODE_EXT16)
					&& (code != wfd_pkg::LEN_CODE_EXT64);
			end
			PH_EXT16, PH_EXT64: begin
				push_op.payload_length = len_clamped;
				push_op.last           = (len_clamped == 64'd0);
				push = acc && ext_done && !mask_q;
			end
			PH_KEY: begin
				push_op.last = (length_q == 64'd0);
				push = acc && (cnt_nxt == wfd_pkg::KEY_BYTES);
			end
			PH_DATA: begin
				push_op.kind     = wfd_pkg::KIND_PAYLOAD;
				push_op.raw_byte = in_byte;
				push_op.key_byte = mask_q ? key_byte : 8'd0;
				push_op.last     = (bytes_left_nxt == 64'd0);
				push = acc;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HDR0;
			field_count_q <= 4'd0;
			fin_q         <= 1'b0;
			opcode_q      <= 4'd0;
			mask_q        <= 1'b0;
			length_q      <= 64'd0;
			bytes_left_q  <= 64'd0;
			mask_key_q    <= 32'd0;
			mask_index_q  <= 2'd0;
		end else if (acc) begin
			case (phase_q)
				PH_HDR0: begin
					fin_q    <= in_byte[7];
					opcode_q <= in_byte[3:0];
					phase_q  <= PH_HDR1;
				end
				PH_HDR1: begin
					mask_q        <= in_byte[7];
					field_count_q <= 4'd0;
					if (code == wfd_pkg::LEN_CODE_EXT16) begin
						length_q <= 64'd0;
						phase_q  <= PH_EXT16;
					end else if (code == wfd_pkg::LEN_CODE_EXT64) begin
						length_q <= 64'd0;
						phase_q  <= PH_EXT64;
					end else begin
						length_q <= {57'd0, code};
						if (in_byte[7]) begin
							phase_q <= PH_KEY;
						end else begin
							bytes_left_q <= {57'd0, code};
							mask_index_q <= 2'd0;
							phase_q      <= (code == 7'd0) ? PH_HDR0 : PH_DATA;
						end
					end
				end
				PH_EXT16, PH_EXT64: begin
					if (ext_done) begin
						length_q      <= len_clamped;
						field_count_q <= 4'd0;
						if (mask_q) begin
							phase_q <= PH_KEY;
						end else begin
							bytes_left_q <= len_clamped;
							mask_index_q <= 2'd0;
							phase_q      <= (len_clamped == 64'd0) ? PH_HDR0 : PH_DATA;
						end
					end else begin
						length_q      <= len_shift;
						field_count_q <= cnt_nxt;
					end
				end
				PH_KEY: begin
					mask_key_q <= {mask_key_q[23:0], in_byte};
					if (cnt_nxt == wfd_pkg::KEY_BYTES) begin
						field_count_q <= 4'd0;
						bytes_left_q  <= length_q;
						mask_index_q  <= 2'd0;
						phase_q       <= (length_q == 64'd0) ? PH_HDR0 : PH_DATA;
					end else begin
						field_count_q <= cnt_nxt;
					end
				end
				PH_DATA: begin
					mask_index_q <= mask_index_q + 2'd1;
					bytes_left_q <= bytes_left_nxt;
					if (bytes_left_nxt == 64'd0) begin
						phase_q <= PH_HDR0;
					end
				end
				default: begin
					phase_q <= PH_HDR0;
				end
			endcase
		end
	end

	// A request that closes a frame sends the parser back to the first header byte
	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_op.last |=> phase_q == PH_HDR0)
		else $error("frame end did not return parser to header start");

	// Field counter never runs past the longest extended length
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		field_count_q < wfd_pkg::EXT64_BYTES)
		else $error("field count out of range");

	// Payload phase always has bytes outstanding
	a_data_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> bytes_left_q != 64'd0)
		else $error("payload phase with no bytes left");

endmodule

// ===== hw/rtl/wfd_queue.sv =====
// Two-entry queue of result requests between parser and output stage.
`timescale 1ns / 1ps
module wfd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  wfd_pkg::wfd_op_t push_op,
	output logic             q_ready,
	input  logic             pop,
	output logic             q_valid,
	output wfd_pkg::wfd_op_t pop_op
);

	wfd_pkg::wfd_op_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign q_ready = (count_q != 2'd2);
	assign q_valid = (count_q != 2'd0);
	assign pop_op  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> q_ready)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("pop from empty queue");

endmodule

// ===== hw/rtl/wfd_back.sv =====
// Back end: unmasks payload bytes and holds the result output register.
`timescale 1ns / 1ps
module wfd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  wfd_pkg::wfd_op_t pop_op,
	output logic             pop,
	wfd_result_if.source     res
);

	logic        out_valid_q;
	logic        kind_q;
	logic        fin_q;
	logic [3:0]  opcode_q;
	logic        masked_q;
	logic [63:0] length_q;
	logic [7:0]  data_q;
	logic        last_q;

	assign pop = q_valid && (!out_valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q   <= pop_op.kind;
			fin_q    <= pop_op.fin;
			opcode_q <= pop_op.opcode;
			masked_q <= pop_op.masked;
			length_q <= pop_op.payload_length;
			data_q   <= pop_op.raw_byte ^ pop_op.key_byte;
			last_q   <= pop_op.last;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.item_kind      = kind_q;
	assign res.fin            = fin_q;
	assign res.opcode         = opcode_q;
	assign res.masked         = masked_q;
	assign res.payload_length = length_q;
	assign res.data_byte      = data_q;
	assign res.last           = last_q;

	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q)
		else $error("popped request not presented");

endmodule

// ===== hw/rtl/websocket_frame_deframer.sv =====
// Top level: WebSocket (RFC 6455) receive-side frame deframer.
//
//  channel  | dir | payload                                             | request
//  ---------+-----+-----------------------------------------------------+----------------------
//  stream   | in  | in_byte[7:0]                                        | one received byte
//  frames   | out | item_kind fin opcode[3:0] masked payload_length[63:0]| header or payload
//           |     | data_byte[7:0] last                                 | byte result
//
//  Throughput: one byte per cycle while the queue has room; every byte is parsed
//  in the cycle it is accepted, so the per-byte state update in the parser sets the rate.
//  Path: the request that a byte completes is written into the queue, then into
//  the output register, before it appears on frames.
//  Reset: arst_n clears parser state to wait for a first header byte and
//  empties the queue and output register; no clearing pass.
//  Stalls: the two-entry queue decouples parser and output; stream stalls
//  while the queue is full, which needs frames held off, and takes bytes
//  again in the cycle after frames accepts.
`timescale 1ns / 1ps
module websocket_frame_deframer (
	input  logic         clk,
	input  logic         arst_n,
	wfd_byte_if.sink     stream,
	wfd_result_if.source frames
);

	logic             push;
	logic             pop;
	logic             q_ready;
	logic             q_valid;
	wfd_pkg::wfd_op_t push_op;
	wfd_pkg::wfd_op_t pop_op;

	// Parser: header fields, extended length, mask key, payload count
	wfd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (stream.valid),
		.in_ready (stream.ready),
		.in_byte  (stream.in_byte),
		.q_ready  (q_ready),
		.push     (push),
		.push_op  (push_op)
	);

	wfd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.q_ready (q_ready),
		.pop     (pop),
		.q_valid (q_valid),
		.pop_op  (pop_op)
	);

	// Unmask and present results
	wfd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.pop_op  (pop_op),
		.pop     (pop),
		.res     (frames)
	);

endmodule
